// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;
  localparam int HeapMax = 65536;
  localparam int HeaderBytes = 24;
  localparam int MinSplit = 8;
  localparam int OffW = 17;
  localparam int AddrW = 13;
  localparam int SizeW = 17;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_INIT = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_EVAL = 3'd4;
  localparam logic [2:0] CMD_ACT1 = 3'd5;
  localparam logic [2:0] CMD_ACT2 = 3'd6;
  localparam logic [2:0] CMD_ACT3 = 3'd7;

  typedef struct packed {
    logic       fin;
    logic       cont;
    logic [1:0] status;
  } stat_t;
endpackage

// ===== rtl/ffha_if.sv =====
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] request_bytes;
  logic [15:0] block_offset;
  modport source(output valid, func, request_bytes, block_offset, input ready);
  modport sink(input valid, func, request_bytes, block_offset, output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] data_offset;
  logic [16:0] used_bytes;
  logic [16:0] free_bytes;
  logic [16:0] total_bytes;
  modport source(output valid, status, data_offset, used_bytes, free_bytes, total_bytes,
                 input ready);
  modport sink(input valid, status, data_offset, used_bytes, free_bytes, total_bytes,
               output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/ffha_datapath.sv =====
module ffha_datapath (
  input  logic                 clk,
  input  logic [2:0]           cmd,
  input  logic                 init_now,
  input  logic [16:0]          cfg_data,
  input  logic                 func,
  input  logic [15:0]          request_bytes,
  input  logic [15:0]          block_offset,
  output ffha_pkg::stat_t      stat,
  output logic [15:0]          data_offset,
  output logic [16:0]          used_bytes,
  output logic [16:0]          free_bytes,
  output logic [16:0]          total_bytes
);
  // Header memory, one word per 8-byte granule. Every word on the chain is
  // written before it is read, so no clearing pass is needed.
  logic [31:0] mem [1 << ffha_pkg::AddrW];
  logic [31:0] rd_r;
  logic        we;
  logic [ffha_pkg::AddrW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [16:0] heap_r, heap_nxt, sat;
  logic [16:0] used_r, used_nxt, free_r, free_nxt;
  logic [16:0] off_r, off_nxt, prev_r, prev_nxt, need_r, need_nxt, tgt_r, tgt_nxt;
  logic [16:0] sz_r, sz_nxt, nxt_r, nxt_nxt, data_r, data_nxt;
  logic        func_r, func_nxt, hasp_r, hasp_nxt;
  logic [16:0] cur_sz, hdr_end, nxt_off;
  logic        cur_free;

  assign cur_sz   = rd_r[16:0];
  assign cur_free = rd_r[31];
  assign hdr_end  = off_r + 17'(ffha_pkg::HeaderBytes);
  assign nxt_off  = hdr_end + cur_sz;

  always_comb begin
    sat = cfg_data;
    if (sat < 17'd64) sat = 17'd64;
    if (32'(sat) > ffha_pkg::HeapMax) sat = 17'(ffha_pkg::HeapMax);
    sat = {sat[16:3], 3'b000};
  end

  always_comb begin
    heap_nxt = heap_r; used_nxt = used_r; free_nxt = free_r;
    off_nxt = off_r; prev_nxt = prev_r; need_nxt = need_r; tgt_nxt = tgt_r;
    sz_nxt = sz_r; nxt_nxt = nxt_r; data_nxt = data_r;
    func_nxt = func_r; hasp_nxt = hasp_r;
    we = 1'b0; waddr = off_r[15:3]; wdata = '0; raddr = off_r[15:3];
    stat = '0;
    if (init_now) begin
      heap_nxt = sat;
      used_nxt = '0;
      free_nxt = (sat >= 17'(ffha_pkg::HeaderBytes)) ? sat - 17'(ffha_pkg::HeaderBytes) : '0;
      we = 1'b1; waddr = '0; wdata = {1'b1, 14'd0, free_nxt};
    end
    unique case (cmd)
      ffha_pkg::CMD_START: begin
        func_nxt = func;
        need_nxt = (17'(request_bytes) + 17'd7) & ~17'd7;
        tgt_nxt  = 17'(block_offset);
        off_nxt = '0; hasp_nxt = 1'b0; data_nxt = '0;
        if (!func && request_bytes == '0) begin
          stat.fin = 1'b1; stat.status = ffha_pkg::ST_ZERO;
        end
      end
      ffha_pkg::CMD_READ: raddr = off_r[15:3];
      ffha_pkg::CMD_EVAL: begin
        sz_nxt = cur_sz; nxt_nxt = nxt_off;
        if (off_r >= heap_r) begin
          stat.fin = 1'b1;
          stat.status = func_r ? ffha_pkg::ST_BADFREE : ffha_pkg::ST_NOFIT;
        end else if (!func_r) begin
          if (cur_free && cur_sz >= need_r) stat.cont = 1'b1;
          else off_nxt = nxt_off;
        end else if (hdr_end == tgt_r) begin
          if (cur_free) begin
            stat.fin = 1'b1; stat.status = ffha_pkg::ST_BADFREE;
          end else begin
            stat.cont = 1'b1;
            used_nxt = used_r - cur_sz; free_nxt = free_r + cur_sz;
          end
        end else if (hdr_end > tgt_r) begin
          stat.fin = 1'b1; stat.status = ffha_pkg::ST_BADFREE;
        end else begin
          prev_nxt = off_r; hasp_nxt = 1'b1; off_nxt = nxt_off;
        end
        raddr = nxt_off[15:3];
      end
      ffha_pkg::CMD_ACT1: begin
        if (!func_r) begin
          // The chosen header itself is rewritten in the next cycle.
          data_nxt = hdr_end;
          if (sz_r >= need_r + 17'(ffha_pkg::HeaderBytes + ffha_pkg::MinSplit)) begin
            we = 1'b1; waddr = 13'((hdr_end + need_r) >> 3);
            wdata = {1'b1, 14'd0, sz_r - need_r - 17'(ffha_pkg::HeaderBytes)};
            sz_nxt = need_r;
            used_nxt = used_r + need_r;
            free_nxt = free_r - need_r - 17'(ffha_pkg::HeaderBytes);
          end else begin
            used_nxt = used_r + sz_r; free_nxt = free_r - sz_r;
          end
        end else begin
          // rd_r holds the successor header here.
          if (nxt_r < heap_r && cur_free) begin
            sz_nxt = sz_r + 17'(ffha_pkg::HeaderBytes) + cur_sz;
            free_nxt = free_r + 17'(ffha_pkg::HeaderBytes);
          end
          raddr = prev_r[15:3];
        end
      end
      ffha_pkg::CMD_ACT2: begin
        we = 1'b1; waddr = off_r[15:3];
        wdata = {func_r, 14'd0, sz_r};
        if (func_r) begin
          if (hasp_r && cur_free) begin
            stat.cont = 1'b1;
            free_nxt = free_r + 17'(ffha_pkg::HeaderBytes);
            sz_nxt = cur_sz + 17'(ffha_pkg::HeaderBytes) + sz_r;
          end else stat.fin = 1'b1;
        end else stat.fin = 1'b1;
      end
      ffha_pkg::CMD_ACT3: begin
        we = 1'b1; waddr = prev_r[15:3]; wdata = {1'b1, 14'd0, sz_r};
        stat.fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
    heap_r <= heap_nxt; used_r <= used_nxt; free_r <= free_nxt;
    off_r <= off_nxt; prev_r <= prev_nxt; need_r <= need_nxt; tgt_r <= tgt_nxt;
    sz_r <= sz_nxt; nxt_r <= nxt_nxt; data_r <= data_nxt;
    func_r <= func_nxt; hasp_r <= hasp_nxt;
  end

  assign data_offset = data_nxt[15:0];
  assign used_bytes  = used_nxt;
  assign free_bytes  = free_nxt;
  assign total_bytes = heap_nxt;
endmodule

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            init_now,
  input  ffha_pkg::stat_t stat,
  output logic [2:0]      cmd,
  output logic            done
);
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_ACT1 = 3'd4;
  localparam logic [2:0] S_ACT2 = 3'd5;
  localparam logic [2:0] S_ACT3 = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign init_now = (state_r == S_INIT) || (cfg_valid && state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r; cmd = ffha_pkg::CMD_NONE;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: if (in_valid && !cfg_valid) begin
        cmd = ffha_pkg::CMD_START; state_nxt = S_READ;
      end
      S_READ: begin cmd = ffha_pkg::CMD_READ; state_nxt = S_EVAL; end
      S_EVAL: begin
        cmd = ffha_pkg::CMD_EVAL;
        state_nxt = stat.cont ? S_ACT1 : S_EVAL;
      end
      S_ACT1: begin cmd = ffha_pkg::CMD_ACT1; state_nxt = S_ACT2; end
      S_ACT2: begin cmd = ffha_pkg::CMD_ACT2; state_nxt = S_ACT3; end
      S_ACT3: begin cmd = ffha_pkg::CMD_ACT3; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
    if (stat.fin) state_nxt = S_IDLE;
  end

  assign done = stat.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a chain of 24-byte block headers. Each beat
// on the input channel is an allocate or a free; each produces one result beat.
// An item walks the block chain one header per cycle through a header memory
// with separate read and write ports. After the accepting cycle it reads the
// first header, evaluates each visited block in turn (plus a final evaluation
// when the walk runs off the end of the heap), then runs the update states
// ACT1 and ACT2 for an allocate, and ACT3 as well for a free that merges
// backward; a zero-size allocate finishes in the accepting cycle itself. The
// result beat is presented in the cycle after the last of these, and the next
// input beat is taken only in the cycle after the result beat has left, so
// items never overlap. A configuration beat re-initializes the heap and is
// accepted only between items.
module first_fit_heap_allocator (
  input  logic clk,
  input  logic rst_n,
  ffha_in_if.sink    in_ch,
  ffha_out_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);
  ffha_pkg::stat_t stat;
  logic [2:0]  cmd;
  logic        init_now, done, idle_ready, out_full_r;
  logic [1:0]  st_r;
  logic [15:0] do_w, do_r;
  logic [16:0] ub_w, fb_w, tb_w, ub_r, fb_r, tb_r;
  logic [16:0] cfg_eff;

  // Reset reinitializes to the full heap size.
  assign cfg_eff = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : 17'(ffha_pkg::HeapMax);

  ffha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid && !out_full_r), .in_ready(idle_ready),
    .cfg_valid(cfg_ch.valid && !out_full_r), .init_now(init_now),
    .stat(stat), .cmd(cmd), .done(done)
  );

  ffha_datapath u_dp (
    .clk(clk), .cmd(cmd), .init_now(init_now), .cfg_data(cfg_eff),
    .func(in_ch.func), .request_bytes(in_ch.request_bytes),
    .block_offset(in_ch.block_offset), .stat(stat),
    .data_offset(do_w), .used_bytes(ub_w), .free_bytes(fb_w), .total_bytes(tb_w)
  );

  assign in_ch.ready  = idle_ready && !out_full_r && !cfg_ch.valid;
  assign cfg_ch.ready = idle_ready && !out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (done) out_full_r <= 1'b1;
    else if (out_ch.ready) out_full_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      st_r <= stat.status; do_r <= do_w; ub_r <= ub_w; fb_r <= fb_w; tb_r <= tb_w;
    end
  end

  assign out_ch.valid       = out_full_r;
  assign out_ch.status      = st_r;
  assign out_ch.data_offset = do_r;
  assign out_ch.used_bytes  = ub_r;
  assign out_ch.free_bytes  = fb_r;
  assign out_ch.total_bytes = tb_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r |-> !done) else $error("result produced while output full");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !cfg_ch.ready || !cfg_ch.valid)
    else $error("config and item in same cycle");
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  // Expected result of one beat, predicted when the input beat is accepted.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_offset;
    logic [16:0] used_bytes;
    logic [16:0] free_bytes;
    logic [16:0] total_bytes;
  } heap_result_t;

  localparam logic [31:0] FreeFlag = 32'h8000_0000;

  logic clk;
  logic rst_n;

  ffha_in_if  in_ch();
  ffha_out_if out_ch();
  ffha_cfg_if cfg_ch();

  first_fit_heap_allocator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // The clock runs with a period of 10 time units.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the heap. Each word holds the free flag in bit 31 and the
  // data size below it, indexed by the byte offset of the block header.
  logic [31:0]  shadow_hdr [0:ffha_pkg::HeapMax-1];
  int unsigned  arena_bytes;
  int unsigned  used_sum;
  int unsigned  free_sum;

  heap_result_t pending_results[$];
  logic [15:0]  live_blocks[$];
  int           error_count;
  int           result_count;
  int           free_ok_count;
  int           config_count;

  // Idling controls. When quiet is set, the side adds no random idle gaps.
  bit           send_quiet;
  bit           recv_quiet;
  int           recv_hold_left;

  // A configuration write saturates the size into the legal range, rounds it
  // down to a multiple of 8, and rebuilds the heap as one free block.
  task automatic shadow_init(input logic [16:0] size_reg);
    int unsigned h;
    int unsigned first_size;
    h = size_reg;
    if (h < 64) h = 64;
    if (h > ffha_pkg::HeapMax) h = ffha_pkg::HeapMax;
    h = h & ~32'd7;
    arena_bytes = h;
    for (int i = 0; i < ffha_pkg::HeapMax; i++) shadow_hdr[i] = '0;
    first_size = (h >= ffha_pkg::HeaderBytes) ? h - ffha_pkg::HeaderBytes : 0;
    shadow_hdr[0] = FreeFlag | first_size;
    used_sum = 0;
    free_sum = first_size;
    live_blocks.delete();
  endtask

  // First-fit allocation: walks the chain from offset zero and splits the
  // chosen block when the remainder can hold a header plus a minimum block.
  function automatic logic [1:0] shadow_alloc(input logic [15:0] req,
                                              output logic [15:0] data_off);
    int unsigned p;
    int unsigned need;
    int unsigned sz;
    p = 0;
    data_off = '0;
    if (req == 0) return ffha_pkg::ST_ZERO;
    need = (int'(req) + 7) & ~32'd7;
    while (p < arena_bytes) begin
      sz = shadow_hdr[p] & ~FreeFlag;
      if (shadow_hdr[p][31] && sz >= need) begin
        if (sz >= need + ffha_pkg::HeaderBytes + ffha_pkg::MinSplit) begin
          shadow_hdr[p + ffha_pkg::HeaderBytes + need] =
            FreeFlag | (sz - need - ffha_pkg::HeaderBytes);
          shadow_hdr[p] = need;
          used_sum += need;
          free_sum -= need + ffha_pkg::HeaderBytes;
        end else begin
          shadow_hdr[p] = sz;
          used_sum += sz;
          free_sum -= sz;
        end
        data_off = 16'(p + ffha_pkg::HeaderBytes);
        return ffha_pkg::ST_DONE;
      end
      p = p + ffha_pkg::HeaderBytes + sz;
    end
    return ffha_pkg::ST_NOFIT;
  endfunction

  // Free: only the exact data offset of an allocated block is honored. The
  // freed block merges forward first, then backward into a free predecessor.
  function automatic logic [1:0] shadow_free(input logic [15:0] target);
    int unsigned p;
    int unsigned prev;
    int unsigned sz;
    int unsigned nxt;
    bit          has_prev;
    p = 0;
    prev = 0;
    has_prev = 1'b0;
    while (p < arena_bytes) begin
      sz = shadow_hdr[p] & ~FreeFlag;
      nxt = p + ffha_pkg::HeaderBytes + sz;
      if (p + ffha_pkg::HeaderBytes == target) begin
        if (shadow_hdr[p][31]) return ffha_pkg::ST_BADFREE;
        used_sum -= sz;
        free_sum += sz;
        if (nxt < arena_bytes && shadow_hdr[nxt][31]) begin
          sz += ffha_pkg::HeaderBytes + (shadow_hdr[nxt] & ~FreeFlag);
          free_sum += ffha_pkg::HeaderBytes;
        end
        shadow_hdr[p] = FreeFlag | sz;
        // The first block has no predecessor, so it only merges forward.
        if (has_prev && shadow_hdr[prev][31]) begin
          shadow_hdr[prev] = FreeFlag |
            ((shadow_hdr[prev] & ~FreeFlag) + ffha_pkg::HeaderBytes + sz);
          free_sum += ffha_pkg::HeaderBytes;
        end
        return ffha_pkg::ST_DONE;
      end
      if (p + ffha_pkg::HeaderBytes > target) return ffha_pkg::ST_BADFREE;
      prev = p;
      has_prev = 1'b1;
      p = nxt;
    end
    return ffha_pkg::ST_BADFREE;
  endfunction

  function automatic heap_result_t predict_heap(input logic f, input logic [15:0] req,
                                                input logic [15:0] off);
    heap_result_t r;
    logic [15:0]  d;
    d = '0;
    if (!f) begin
      r.status = shadow_alloc(req, d);
      if (r.status == ffha_pkg::ST_DONE) live_blocks.push_back(d);
    end else begin
      r.status = shadow_free(off);
      if (r.status == ffha_pkg::ST_DONE) begin
        for (int i = 0; i < live_blocks.size(); i++) begin
          if (live_blocks[i] == off) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
    end
    r.data_offset = d;
    r.used_bytes  = used_sum[16:0];
    r.free_bytes  = free_sum[16:0];
    r.total_bytes = arena_bytes[16:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at result %0d: %s", result_count, what);
  endtask

  // Sends one request beat after a random gap, then records what it should give.
  task automatic send_request(input logic f, input logic [15:0] req,
                              input logic [15:0] off);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.func          = f;
    in_ch.request_bytes = req;
    in_ch.block_offset  = off;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_heap(f, req, off));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Waits until every expected result has come back.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // The register is only written while the block is idle. Every item yields a
  // result, so an empty queue means the block has finished its work.
  task automatic write_heap_size(input logic [16:0] size_reg);
    drain_results();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = size_reg;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_init(size_reg);
    config_count++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic alloc_req(input logic [15:0] req);
    send_request(1'b0, req, 16'($urandom()));
  endtask

  task automatic free_req(input logic [15:0] off);
    send_request(1'b1, 16'($urandom()), off);
  endtask

  // Result checker: every accepted result beat is compared to the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (out_ch.status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, e.status));
        if (out_ch.data_offset !== e.data_offset)
          report_mismatch($sformatf("data_offset %0d, expected %0d",
                                    out_ch.data_offset, e.data_offset));
        if (out_ch.used_bytes !== e.used_bytes)
          report_mismatch($sformatf("used_bytes %0d, expected %0d",
                                    out_ch.used_bytes, e.used_bytes));
        if (out_ch.free_bytes !== e.free_bytes)
          report_mismatch($sformatf("free_bytes %0d, expected %0d",
                                    out_ch.free_bytes, e.free_bytes));
        if (out_ch.total_bytes !== e.total_bytes)
          report_mismatch($sformatf("total_bytes %0d, expected %0d",
                                    out_ch.total_bytes, e.total_bytes));
      end
    end
  end

  // Result receiver: stalls a random number of cycles per beat, and holds off
  // entirely while a long hold is being counted down.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0 || recv_hold_left > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
        while (recv_hold_left > 0) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // The long hold is counted down in a process of its own.
  always @(negedge clk) begin
    if (recv_hold_left > 0) recv_hold_left <= recv_hold_left - 1;
  end

  // Directed cases at the reset size and on the smallest heap.
  task automatic test_directed();
    alloc_req(16'd0);          // zero size is rejected
    alloc_req(16'hFFFF);       // larger than the whole heap
    alloc_req(16'd1);          // rounds up to 8, lands at offset 24
    alloc_req(16'd8);
    alloc_req(16'd40);
    free_req(16'd24);          // first block: no predecessor
    free_req(16'd24);          // already free
    free_req(16'd57);          // misaligned
    free_req(16'd60);          // points inside a block
    free_req(16'hFFFF);        // inside the last block
    free_req(16'd0);           // header offset, never a data offset
    free_req(16'd88);          // merges with the large free tail
    free_req(16'd56);          // merges both ways back to one block
    write_heap_size(17'd64);
    alloc_req(16'd33);         // exact fit, no split
    alloc_req(16'd1);          // nothing left
    free_req(16'd24);
    alloc_req(16'd16);         // remainder too small to split
    free_req(16'd24);
    alloc_req(16'd8);          // split leaves a minimum block
    alloc_req(16'd8);
    free_req(16'd24);
  endtask

  // Random traffic. Most frees target live blocks; the rest are stray offsets.
  // Most requests are small, with a few of full random width.
  task automatic test_random(input int count, input int max_req);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) == 0) alloc_req(16'($urandom()));
        else alloc_req(16'($urandom_range(1, max_req)));
      end else if (pick < 90 && live_blocks.size() != 0) begin
        free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if (pick < 95) begin
        free_req(16'($urandom()));
      end else begin
        free_req(16'($urandom_range(0, arena_bytes) & ~32'd7));
      end
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    send_quiet = 1'b1;
    recv_hold_left = 400;
    for (int n = 0; n < 12; n++) alloc_req(16'($urandom_range(1, 64)));
    send_quiet = 1'b0;
  endtask

  // The sender pauses until every result has come back, then resumes.
  task automatic test_pause();
    test_random(20, 128);
    drain_results();
    test_random(20, 128);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.request_bytes = '0;
    in_ch.block_offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    recv_hold_left = 0;
    error_count = 0;
    result_count = 0;
    config_count = 0;
    shadow_init(17'd65536);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    write_heap_size(17'd65536);
    test_random(200, 256);
    test_backpressure();
    test_pause();
    write_heap_size(17'd0);        // saturates up to the smallest heap
    test_random(80, 48);
    write_heap_size(17'h1FFFF);    // saturates down to the largest heap
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    test_random(150, 512);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    write_heap_size(17'd100);      // not a multiple of 8
    test_random(80, 64);
    write_heap_size(17'd65535);
    test_random(150, 2048);
    write_heap_size(17'd512);
    test_random(150, 96);
    write_heap_size(17'd4096);
    test_random(150, 300);

    drain_results();
    repeat (100) @(posedge clk);
    $display("covered %0d results over %0d heap sizes, %0d frees honored,",
             result_count, config_count + 1, free_ok_count);
    $display("with random stalls, a long receiver hold and a drained pause");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    free_ok_count = 0;
    #100000000;
    $display("simulation failed");
    $finish;
  end

  // Counts honored frees for the summary: a successful beat with no data
  // offset can only come from a free.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == ffha_pkg::ST_DONE
        && out_ch.data_offset == 16'd0)
      free_ok_count <= free_ok_count + 1;
  end
endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
bench/tb_top.sv
